### sv/msfl_pkg.sv
// msfl_pkg: shared types and constants for the multi-stack shared free list
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none
package msfl_pkg;

  localparam int SID_W          = 3;
  localparam int DATA_W         = 32;
  localparam int DEF_NUM_STACKS = 8;
  localparam int DEF_CAPACITY   = 64;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [SID_W-1:0]         stack_id;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] pop_value;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } msfl_cmd_t;

endpackage
`default_nettype wire

### sv/msfl_ram.sv
// msfl_ram: generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none
module msfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/msfl_ctrl.sv
// msfl_ctrl: sequencing state machine (accept, then commit in the following cycle)
// depends on msfl_pkg
`default_nettype none
module msfl_ctrl
  import msfl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output msfl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/msfl_dp.sv
// msfl_dp: stack tops, free head, fill count and the data and link rams
// depends on msfl_pkg and msfl_ram
`default_nettype none
module msfl_dp
  import msfl_pkg::*;
#(
  parameter int NUM_STACKS = DEF_NUM_STACKS,
  parameter int CAPACITY   = DEF_CAPACITY
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire msfl_cmd_t cmd,
  input  wire in_word_t  in_word,
  output out_word_t      out_word
);

  localparam int PTR_W     = $clog2(CAPACITY + 1);
  localparam int AW        = $clog2(CAPACITY);
  localparam int SID_MAX   = 2 ** SID_W;
  localparam int TOP_DEPTH = (NUM_STACKS < SID_MAX) ? NUM_STACKS : SID_MAX;
  localparam int TOP_IW    = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

  logic [PTR_W-1:0]  top_r [TOP_DEPTH];
  logic [PTR_W-1:0]  free_head_r;
  logic [PTR_W-1:0]  fill_r;

  logic              kind_r;
  logic [TOP_IW-1:0] sid_r;
  logic [DATA_W-1:0] value_r;
  logic [PTR_W-1:0]  ent_r;
  logic              hit_r;
  out_word_t         out_word_r;

  logic              sid_ok;
  logic [TOP_IW-1:0] sid_idx;
  logic [PTR_W-1:0]  ent_sel;
  logic              hit_sel;

  logic [PTR_W-1:0]  link_rdata;
  logic [DATA_W-1:0] data_rdata;
  logic [PTR_W-1:0]  link_val;
  logic              fresh;
  logic              link_we;
  logic              data_we;
  logic [PTR_W-1:0]  link_wdata;

  // entry pick at accept time
  always_comb begin
    sid_ok  = (32'(in_word.stack_id) < NUM_STACKS);
    sid_idx = in_word.stack_id[TOP_IW-1:0];
    ent_sel = free_head_r;
    if (in_word.kind == KIND_POP) begin
      ent_sel = sid_ok ? top_r[sid_idx] : NULL_PTR;
    end
    hit_sel = sid_ok && (ent_sel < NULL_PTR);
  end

  // entries at or above the fill count are still in their reset chain
  always_comb begin
    fresh      = (ent_r >= fill_r);
    link_val   = fresh ? (ent_r + PTR_W'(1)) : link_rdata;
    link_we    = cmd.commit && hit_r;
    data_we    = cmd.commit && hit_r && (kind_r == KIND_PUSH);
    link_wdata = (kind_r == KIND_PUSH) ? top_r[sid_r] : free_head_r;
  end

  msfl_ram #(
    .WIDTH (PTR_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (ent_r[AW-1:0]),
    .wdata (link_wdata),
    .re    (cmd.accept),
    .raddr (ent_sel[AW-1:0]),
    .rdata (link_rdata)
  );

  msfl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (ent_r[AW-1:0]),
    .wdata (value_r),
    .re    (cmd.accept),
    .raddr (ent_sel[AW-1:0]),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_word.kind;
      sid_r   <= sid_idx;
      value_r <= in_word.value;
      ent_r   <= ent_sel;
      hit_r   <= hit_sel;
    end
    if (cmd.commit) begin
      out_word_r.ok        <= hit_r;
      out_word_r.pop_value <= (hit_r && (kind_r == KIND_POP)) ? data_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOP_DEPTH; i++) begin
        top_r[i] <= NULL_PTR;
      end
      free_head_r <= '0;
      fill_r      <= '0;
    end else if (cmd.commit && hit_r) begin
      if (kind_r == KIND_PUSH) begin
        free_head_r  <= link_val;
        top_r[sid_r] <= ent_r;
        if (fresh) begin
          fill_r <= fill_r + PTR_W'(1);
        end
      end else begin
        top_r[sid_r] <= link_val;
        free_head_r  <= ent_r;
      end
    end
  end

  assign out_word = out_word_r;

endmodule
`default_nettype wire

### sv/multi_stack_shared_free_list.sv
// multi_stack_shared_free_list: several lifo stacks sharing one entry store
// depends on msfl_pkg, msfl_ctrl, msfl_dp (and msfl_ram below it)
//
// usage
//   a command word (push or pop, stack number, data word) is taken at a
//   rising edge where start is high and busy is low. busy then stays high
//   until the command has been committed, so a new command is not taken
//   before the last one is through; this is set by the read of the link
//   ram that follows the read of a stack top or the free head.
//   each command gives exactly one result word: out_valid is high for one
//   cycle, registered from the commit step, with out_word.ok and
//   out_word.pop_value. the receiver cannot stall, so the result is lost
//   unless taken in that cycle.
//   a push fails (ok low) when every entry is in use, a pop fails when
//   its stack is empty, and both fail for a stack number at or above
//   NUM_STACKS. pop_value is zero except on a successful pop.
//   reset (synchronous, active low) empties all stacks and frees all
//   entries at once; untouched entries are tracked by a fill count, so no
//   clearing pass over the rams is needed.
`default_nettype none
module multi_stack_shared_free_list
  import msfl_pkg::*;
#(
  parameter int NUM_STACKS = DEF_NUM_STACKS,
  parameter int CAPACITY   = DEF_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  msfl_cmd_t cmd;

  msfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  msfl_dp #(
    .NUM_STACKS (NUM_STACKS),
    .CAPACITY   (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: random and directed push/pop traffic for multi_stack_shared_free_list,
// every result word checked against a behavioral model of the shared entry store
// depends on msfl_pkg and multi_stack_shared_free_list
`default_nettype none
module tb_top
  import msfl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTK = DEF_NUM_STACKS;
  localparam int CAP = DEF_CAPACITY;
  localparam int LINK_W = $clog2(CAP + 1);
  localparam int RANDOM_WORDS = 800;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_valid;
  out_word_t out_word;

  multi_stack_shared_free_list uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_word(out_word)
  );

  logic signed [DATA_W-1:0] entry_val[CAP];
  logic [LINK_W-1:0] entry_next[CAP];
  logic [LINK_W-1:0] stack_head[NSTK];
  logic [LINK_W-1:0] free_ptr;

  in_word_t cmd_words[$];
  out_word_t due_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int steady_left = 0;

  function automatic out_word_t stack_op_result(in_word_t w);
    out_word_t r;
    int e;
    r = '0;
    if (w.stack_id < NSTK) begin
      if (w.kind == KIND_PUSH) begin
        e = int'(free_ptr);
        if (e < CAP) begin
          free_ptr = entry_next[e];
          entry_val[e] = w.value;
          entry_next[e] = stack_head[w.stack_id];
          stack_head[w.stack_id] = LINK_W'(e);
          r.ok = 1'b1;
        end
      end else begin
        e = int'(stack_head[w.stack_id]);
        if (e < CAP) begin
          stack_head[w.stack_id] = entry_next[e];
          entry_next[e] = free_ptr;
          free_ptr = LINK_W'(e);
          r.pop_value = entry_val[e];
          r.ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int idle_cycles();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(input logic kind, input int sid, input logic signed [DATA_W-1:0] val);
    in_word_t w;
    w.kind = kind;
    w.stack_id = SID_W'(sid);
    w.value = val;
    cmd_words.push_back(w);
  endtask

  task automatic build_traffic();
    int n;
    int phase_len;
    int push_pct;
    int sid_lo;
    int sid_hi;
    add_cmd(KIND_POP, 0, 32'sh12345678);
    add_cmd(KIND_POP, NSTK - 1, 32'shedcba987);
    add_cmd(KIND_PUSH, 0, 32'sh7fffffff);
    add_cmd(KIND_PUSH, 0, 32'sh80000000);
    add_cmd(KIND_PUSH, NSTK - 1, '0);
    add_cmd(KIND_PUSH, NSTK - 1, '1);
    add_cmd(KIND_PUSH, 3, 32'sh55555555);
    add_cmd(KIND_PUSH, 4, 32'shaaaaaaaa);
    add_cmd(KIND_PUSH, 1, 32'sh00000001);
    add_cmd(KIND_PUSH, 2, 32'shfffffffe);
    add_cmd(KIND_PUSH, 5, 32'sh0f0f0f0f);
    add_cmd(KIND_PUSH, 6, 32'shf0f0f0f0);
    add_cmd(KIND_POP, 0, '1);
    add_cmd(KIND_POP, 0, '0);
    add_cmd(KIND_POP, 0, 32'sh55555555);
    add_cmd(KIND_POP, NSTK - 1, 32'shaaaaaaaa);
    add_cmd(KIND_PUSH, 0, 32'sh00c0ffee);
    add_cmd(KIND_POP, NSTK - 1, '0);
    add_cmd(KIND_POP, NSTK - 1, '0);
    add_cmd(KIND_POP, 3, '0);
    add_cmd(KIND_POP, 4, '0);
    add_cmd(KIND_POP, 0, '0);
    n = 0;
    while (n < RANDOM_WORDS) begin
      phase_len = $urandom_range(30, 110);
      case ($urandom_range(0, 3))
        0: push_pct = 90;
        1: push_pct = 15;
        2: push_pct = 55;
        default: push_pct = 75;
      endcase
      if ($urandom_range(0, 2) == 0) begin
        sid_lo = $urandom_range(0, NSTK - 1);
        sid_hi = sid_lo;
      end else begin
        sid_lo = 0;
        sid_hi = NSTK - 1;
      end
      for (int i = 0; i < phase_len && n < RANDOM_WORDS; i++) begin
        add_cmd(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP,
                $urandom_range(sid_lo, sid_hi), pick_value());
        n++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    for (int i = 0; i < CAP; i++) begin
      entry_val[i] = '0;
      entry_next[i] = LINK_W'(i + 1);
    end
    for (int i = 0; i < NSTK; i++) stack_head[i] = LINK_W'(CAP);
    free_ptr = '0;
    build_traffic();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (cmd_words.size() > 0 || start) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(stack_op_result(in_word));
        gap_left = idle_cycles();
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_words.size() > 0) begin
        start <= 1'b1;
        in_word <= cmd_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: ok %0d pop_value %0d",
               out_word.ok, out_word.pop_value);
        fail_count++;
      end else begin
        exp_word = due_results.pop_front();
        if (out_word.ok !== exp_word.ok) begin
          $error("ok: expected %0d, actual %0d", exp_word.ok, out_word.ok);
          fail_count++;
        end
        if (out_word.pop_value !== exp_word.pop_value) begin
          $error("pop_value: expected %0d, actual %0d", exp_word.pop_value, out_word.pop_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
